>>> rtl/crm_pkg.sv
// Shared types and constants for the cyclic rotation match block.
package crm_pkg;

    // Default capacity of each element store.
    localparam int CRM_MAX_LEN = 64;

    // Width of one array element.
    localparam int CRM_DATA_W = 32;

    // Width of the reported rotation amount.
    localparam int CRM_SHIFT_W = 6;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CHECK,
        ST_EMIT
    } t_state;

    // One result as handed from the sequencer to the output register.
    typedef struct packed {
        logic                   overflow;
        logic [CRM_SHIFT_W-1:0] shift;
        logic                   match;
    } t_res;

endpackage

>>> rtl/cyclic_rotation_match.sv
// Cyclic rotation match: element stores, sequencer and result register.
//
// Element pairs stream in at one per cycle while the block is loading; the
// pair with tlast set closes the batch. The block then tries right rotations
// of the second array in increasing order with a single 32-bit comparator fed
// by one registered read port on each store. Each rotation compares up to n
// address pairs (n = stored length, up to MAX_LEN), one per cycle, and a
// mismatch restarts the walk on the next amount in the following cycle.
// After the check the result is handed to the output register; input is not
// taken during the check or while the result waits for the output register
// to free up. Exactly one result follows each batch. Pairs beyond MAX_LEN are
// dropped and reported through the overflow bit. No clearing pass is needed
// after reset.
module cyclic_rotation_match #(
    parameter int MAX_LEN = crm_pkg::CRM_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // a_value [31:0], b_value [63:32]
    input  logic        i_s_tlast,   // last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // match [0], shift [6:1], overflow [7]
);

    import crm_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr_a;
    logic [AW-1:0]         rd_addr_b;
    logic [CRM_DATA_W-1:0] rd_a;
    logic [CRM_DATA_W-1:0] rd_b;
    logic                  res_vld;
    logic                  res_rdy;
    t_res                  res;

    logic                  r_out_vld;
    t_res                  r_out;

    // Reference array store.
    crm_ram #(
        .WIDTH (CRM_DATA_W),
        .DEPTH (MAX_LEN)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata[CRM_DATA_W-1:0]),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (rd_a)
    );

    // Rotated array store.
    crm_ram #(
        .WIDTH (CRM_DATA_W),
        .DEPTH (MAX_LEN)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata[2*CRM_DATA_W-1:CRM_DATA_W]),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (rd_b)
    );

    // Sequencer with the shared comparator.
    crm_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tlast   (i_s_tlast),
        .o_s_tready  (o_s_tready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .o_res_vld   (res_vld),
        .i_res_rdy   (res_rdy),
        .o_res       (res)
    );

    // Output register takes a new result when empty or being drained.
    assign res_rdy = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_rdy) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    // The cycle after a closing pair is accepted, no further pair is taken.
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input taken right after a closing pair");

    // A result with no match reports a zero amount.
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> (o_m_tdata[6:1] == 6'd0))
        else $error("nonzero shift without a match");

    // A reported amount stays below the store depth.
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((MAX_LEN > 64) || ({26'd0, o_m_tdata[6:1]} < 32'(MAX_LEN))))
        else $error("shift beyond the stored length");

    // A result is handed over only while the input side is closed.
    a_res_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> !o_s_tready)
        else $error("result pending while input open");

endmodule

>>> rtl/crm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module crm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/crm_seq.sv
// Load counter, rotation sequencer and shared element comparator.
module crm_seq #(
    parameter int MAX_LEN = crm_pkg::CRM_MAX_LEN,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tlast,
    output logic                           o_s_tready,
    output logic                           o_wr_en,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [AW-1:0]                  o_rd_addr_a,
    output logic [AW-1:0]                  o_rd_addr_b,
    input  logic [crm_pkg::CRM_DATA_W-1:0] i_rd_a,
    input  logic [crm_pkg::CRM_DATA_W-1:0] i_rd_b,
    output logic                           o_res_vld,
    input  logic                           i_res_rdy,
    output crm_pkg::t_res                  o_res
);

    import crm_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          r_issue, n_issue;
    logic          r_pend, n_pend;
    logic          r_pend_last, n_pend_last;
    logic          r_match, n_match;
    logic [AW-1:0] r_nm1, n_nm1;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_src0, n_src0;
    logic [AW-1:0] r_amt, n_amt;

    logic accept;
    logic cnt_full;
    logic eq;
    logic cmp_fail;
    logic cmp_pass;
    logic last_amt;

    assign accept   = i_s_tvalid && o_s_tready;
    assign cnt_full = (r_cnt == CW'(MAX_LEN));
    assign last_amt = (r_amt == r_nm1);

    // The one comparator, fed by both RAM read ports.
    assign eq       = (i_rd_a == i_rd_b);
    assign cmp_fail = (r_state == ST_CHECK) && r_pend && !eq;
    assign cmp_pass = (r_state == ST_CHECK) && r_pend && eq && r_pend_last;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && i_s_tlast) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (cmp_pass || (cmp_fail && last_amt)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_res_rdy) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // State-decoded outputs.
    always_comb begin
        o_s_tready = 1'b0;
        o_res_vld  = 1'b0;
        unique case (r_state)
            ST_LOAD:  o_s_tready = 1'b1;
            ST_CHECK: o_s_tready = 1'b0;
            ST_EMIT:  o_res_vld  = 1'b1;
            default:  o_s_tready = 1'b0;
        endcase
    end

    // Store writes go to the next free entry; reads follow the walk.
    assign o_wr_en     = accept && !cnt_full;
    assign o_wr_addr   = r_cnt[AW-1:0];
    assign o_rd_addr_a = r_i;
    assign o_rd_addr_b = r_src;

    // The result word.
    assign o_res.match    = r_match;
    assign o_res.shift    = r_match ? CRM_SHIFT_W'(r_amt) : '0;
    assign o_res.overflow = r_ovf;

    // Counter and walk updates.
    always_comb begin
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_match     = r_match;
        n_nm1       = r_nm1;
        n_i         = r_i;
        n_src       = r_src;
        n_src0      = r_src0;
        n_amt       = r_amt;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    // Extra pairs are dropped and only flagged.
                    if (!cnt_full) begin
                        n_cnt = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_nm1   = cnt_full ? AW'(MAX_LEN - 1) : r_cnt[AW-1:0];
                        n_i     = '0;
                        n_src   = '0;
                        n_src0  = '0;
                        n_amt   = '0;
                        n_issue = 1'b1;
                        n_pend  = 1'b0;
                        n_match = 1'b0;
                    end
                end
            end
            ST_CHECK: begin
                // Issue one address pair per cycle along the current rotation.
                if (r_issue) begin
                    n_pend      = 1'b1;
                    n_pend_last = (r_i == r_nm1);
                    if (r_i == r_nm1) begin
                        n_issue = 1'b0;
                    end else begin
                        n_i   = r_i + AW'(1);
                        n_src = (r_src == r_nm1) ? '0 : r_src + AW'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                // A mismatch drops the read in flight and starts the next amount.
                if (cmp_fail) begin
                    n_pend  = 1'b0;
                    n_issue = 1'b0;
                    if (!last_amt) begin
                        n_amt   = r_amt + AW'(1);
                        n_src0  = (r_src0 == '0) ? r_nm1 : r_src0 - AW'(1);
                        n_src   = (r_src0 == '0) ? r_nm1 : r_src0 - AW'(1);
                        n_i     = '0;
                        n_issue = 1'b1;
                    end
                end else if (cmp_pass) begin
                    n_match = 1'b1;
                    n_pend  = 1'b0;
                    n_issue = 1'b0;
                end
            end
            ST_EMIT: begin
                if (i_res_rdy) begin
                    n_cnt = '0;
                    n_ovf = 1'b0;
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_issue <= n_issue;
            r_pend  <= n_pend;
        end
    end

    // Walk registers.
    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_match     <= n_match;
        r_nm1       <= n_nm1;
        r_i         <= n_i;
        r_src       <= n_src;
        r_src0      <= n_src0;
        r_amt       <= n_amt;
    end

endmodule
